/* src/pjd_pkg.sv */
// Shared types, codes and default sizes of the priority job dispatcher.
`timescale 1ns / 1ps

package pjd_pkg;

    localparam int MAX_JOBS_DEF        = 512;
    localparam int PRIORITY_LEVELS_DEF = 5;

    localparam int OPCODE_W    = 2;
    localparam int PRIO_REQ_W  = 3;
    localparam int JOB_NUM_W   = 9;
    localparam int STATUS_W    = 3;
    localparam int JOB_ID_W    = 9;
    localparam int COUNT_W     = 10;
    localparam int RUNNING_W   = 7;
    localparam int LIMIT_W     = 7;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 56;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD      = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK          = 3'd0,
        RES_TABLE_FULL  = 3'd1,
        RES_LIMIT       = 3'd2,
        RES_EMPTY       = 3'd3,
        RES_NOT_RUNNING = 3'd4
    } result_t;

    typedef enum logic [1:0] {
        JS_QUEUED  = 2'd0,
        JS_RUNNING = 2'd1,
        JS_DONE    = 2'd2,
        JS_FAILED  = 2'd3
    } job_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } pjd_cmd_t;

endpackage

/* src/priority_job_dispatcher.sv */
// Top level of the strict-priority job dispatcher.
`timescale 1ns / 1ps

// Each command beat passes through the idle and execute states: in the cycle
// of acceptance the head entry of the most urgent non-empty queue and the
// state of the named job are read from their synchronous memories, and in the
// execute state the result is formed, the memories and pointers are updated
// and the result beat is registered. A new command is accepted while the
// previous result still waits to be taken; a stalled result holds the execute
// state. No clearing pass follows reset.
module priority_job_dispatcher
#(
    parameter int MAX_JOBS        = pjd_pkg::MAX_JOBS_DEF,
    parameter int PRIORITY_LEVELS = pjd_pkg::PRIORITY_LEVELS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] priority_req, [11:3] job_number, [12] success, [15:13] zero
    input  logic [pjd_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] opcode
    input  logic [pjd_pkg::OPCODE_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] status, [11:3] job_id, [21:12] queued_total, [28:22] running_count,
    // [38:29] completed_count, [48:39] failed_count, [55:49] zero
    output logic [pjd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_wen,
    input  logic [pjd_pkg::LIMIT_W-1:0]    cfg_wdata
);
    import pjd_pkg::*;

    pjd_cmd_t cmd;

    pjd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pjd_datapath
    #(
        .MAX_JOBS        (MAX_JOBS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .opcode_in     (s_tuser),
        .prio_in       (s_tdata[2:0]),
        .job_number_in (s_tdata[11:3]),
        .success_in    (s_tdata[12]),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .result_data   (m_tdata)
    );

`ifndef SYNTHESIS
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while a command is in progress");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (m_tvalid && s_tready))
        else $error("result beat not presented after a commit");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == RES_OK || m_tdata[2:0] == RES_TABLE_FULL ||
                      m_tdata[2:0] == RES_LIMIT || m_tdata[2:0] == RES_EMPTY ||
                      m_tdata[2:0] == RES_NOT_RUNNING))
        else $error("result beat carries an undefined status");

    a_id_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] != RES_OK) |-> (m_tdata[11:3] == '0))
        else $error("failed command reports a job id");
`endif

endmodule

/* src/pjd_ctrl.sv */
// Controller of the job dispatcher: command sequencing and output beat handshake.
`timescale 1ns / 1ps

module pjd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output pjd_pkg::pjd_cmd_t cmd
);
    import pjd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/pjd_datapath.sv */
// Datapath of the job dispatcher: queue and job state memories, pointers and counters.
`timescale 1ns / 1ps

module pjd_datapath
#(
    parameter int MAX_JOBS        = pjd_pkg::MAX_JOBS_DEF,
    parameter int PRIORITY_LEVELS = pjd_pkg::PRIORITY_LEVELS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pjd_pkg::pjd_cmd_t                 cmd,
    input  logic [pjd_pkg::OPCODE_W-1:0]      opcode_in,
    input  logic [pjd_pkg::PRIO_REQ_W-1:0]    prio_in,
    input  logic [pjd_pkg::JOB_NUM_W-1:0]     job_number_in,
    input  logic                              success_in,
    input  logic                              cfg_wen,
    input  logic [pjd_pkg::LIMIT_W-1:0]       cfg_wdata,
    output logic [pjd_pkg::OUT_DATA_W-1:0]    result_data
);
    import pjd_pkg::*;

    localparam int IDW    = $clog2(MAX_JOBS);
    localparam int CW     = $clog2(MAX_JOBS + 1);
    localparam int PW     = $clog2(PRIORITY_LEVELS);
    localparam int QDEPTH = PRIORITY_LEVELS * MAX_JOBS;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int PAD_W  = OUT_DATA_W - STATUS_W - JOB_ID_W - 3 * COUNT_W - RUNNING_W;

    logic [IDW-1:0]   queue_mem [QDEPTH];
    job_state_t       status_mem [MAX_JOBS];

    opcode_t          op_reg;
    logic [PW-1:0]    prio_reg;
    logic [JOB_NUM_W-1:0] jnum_reg;
    logic             ok_reg;
    logic [IDW-1:0]   q_rdata_reg;
    job_state_t       s_rdata_reg;

    logic [IDW-1:0]   head_reg [PRIORITY_LEVELS];
    logic [IDW-1:0]   head_next [PRIORITY_LEVELS];
    logic [IDW-1:0]   tail_reg [PRIORITY_LEVELS];
    logic [IDW-1:0]   tail_next [PRIORITY_LEVELS];
    logic [CW-1:0]    len_reg [PRIORITY_LEVELS];
    logic [CW-1:0]    len_next [PRIORITY_LEVELS];
    logic [CW-1:0]    slots_reg;
    logic [CW-1:0]    slots_next;
    logic [CW-1:0]    queued_reg;
    logic [CW-1:0]    queued_next;
    logic [RUNNING_W-1:0] running_reg;
    logic [RUNNING_W-1:0] running_next;
    logic [CW-1:0]    done_reg;
    logic [CW-1:0]    done_next;
    logic [CW-1:0]    bad_reg;
    logic [CW-1:0]    bad_next;
    logic [LIMIT_W-1:0] limit_reg;

    result_t          res_status_reg;
    result_t          res_status_next;
    logic [IDW-1:0]   res_id_reg;
    logic [IDW-1:0]   res_id_next;
    logic [CW-1:0]    res_queued_reg;
    logic [RUNNING_W-1:0] res_running_reg;
    logic [CW-1:0]    res_done_reg;
    logic [CW-1:0]    res_bad_reg;

    logic [PW-1:0]    sel;
    logic             any_queued;
    logic [PW-1:0]    prio_clamped;
    logic [QAW-1:0]   q_raddr;
    logic [QAW-1:0]   q_waddr;
    logic             q_we;
    logic [IDW-1:0]   q_wdata;
    logic             s_we;
    logic [IDW-1:0]   s_waddr;
    job_state_t       s_wdata;
    logic [LIMIT_W-1:0] eff_limit;
    logic             do_add;
    logic             do_pop;

    function automatic logic [IDW-1:0] ring_next(input logic [IDW-1:0] pos);
        logic [IDW-1:0] nxt;
        if (pos == IDW'(MAX_JOBS - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = pos + 1'b1;
        end
        return nxt;
    endfunction

    always_comb
    begin
        sel        = '0;
        any_queued = 1'b0;
        for (int p = PRIORITY_LEVELS - 1; p >= 0; p--)
        begin
            if (len_reg[p] != '0)
            begin
                sel        = PW'(p);
                any_queued = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (32'(prio_in) >= 32'(PRIORITY_LEVELS))
        begin
            prio_clamped = PW'(PRIORITY_LEVELS - 1);
        end
        else
        begin
            prio_clamped = PW'(prio_in);
        end
    end

    assign q_raddr = QAW'(QAW'(sel) * QAW'(MAX_JOBS)) + QAW'(head_reg[sel]);
    assign q_waddr = QAW'(QAW'(prio_reg) * QAW'(MAX_JOBS)) + QAW'(tail_reg[prio_reg]);
    assign eff_limit = (limit_reg == '0) ? LIMIT_W'(1) : limit_reg;

    always_comb
    begin
        res_status_next = RES_OK;
        res_id_next     = '0;
        slots_next      = slots_reg;
        queued_next     = queued_reg;
        running_next    = running_reg;
        done_next       = done_reg;
        bad_next        = bad_reg;
        q_we            = 1'b0;
        q_wdata         = IDW'(slots_reg);
        s_we            = 1'b0;
        s_waddr         = IDW'(slots_reg);
        s_wdata         = JS_QUEUED;
        do_add          = 1'b0;
        do_pop          = 1'b0;
        unique case (op_reg)
            OP_ADD:
            begin
                if (slots_reg >= CW'(MAX_JOBS))
                begin
                    res_status_next = RES_TABLE_FULL;
                end
                else
                begin
                    do_add      = 1'b1;
                    res_id_next = IDW'(slots_reg);
                    q_we        = cmd.commit;
                    s_we        = cmd.commit;
                    slots_next  = slots_reg + 1'b1;
                    queued_next = queued_reg + 1'b1;
                end
            end
            OP_DISPATCH:
            begin
                if (running_reg >= eff_limit)
                begin
                    res_status_next = RES_LIMIT;
                end
                else if (!any_queued)
                begin
                    res_status_next = RES_EMPTY;
                end
                else
                begin
                    do_pop       = 1'b1;
                    res_id_next  = q_rdata_reg;
                    s_we         = cmd.commit;
                    s_waddr      = q_rdata_reg;
                    s_wdata      = JS_RUNNING;
                    running_next = running_reg + 1'b1;
                    queued_next  = queued_reg - 1'b1;
                end
            end
            OP_COMPLETE:
            begin
                if ((32'(jnum_reg) >= 32'(slots_reg)) || (s_rdata_reg != JS_RUNNING))
                begin
                    res_status_next = RES_NOT_RUNNING;
                end
                else
                begin
                    res_id_next  = IDW'(jnum_reg);
                    s_we         = cmd.commit;
                    s_waddr      = IDW'(jnum_reg);
                    s_wdata      = ok_reg ? JS_DONE : JS_FAILED;
                    running_next = running_reg - 1'b1;
                    if (ok_reg)
                    begin
                        done_next = done_reg + 1'b1;
                    end
                    else
                    begin
                        bad_next = bad_reg + 1'b1;
                    end
                end
            end
            OP_NONE:
            begin
                res_status_next = RES_OK;
            end
            default:
            begin
                res_status_next = RES_OK;
            end
        endcase
    end

    always_comb
    begin
        for (int p = 0; p < PRIORITY_LEVELS; p++)
        begin
            head_next[p] = head_reg[p];
            tail_next[p] = tail_reg[p];
            len_next[p]  = len_reg[p];
            if (do_add && (prio_reg == PW'(p)))
            begin
                tail_next[p] = ring_next(tail_reg[p]);
                len_next[p]  = len_reg[p] + 1'b1;
            end
            if (do_pop && (sel == PW'(p)))
            begin
                head_next[p] = ring_next(head_reg[p]);
                len_next[p]  = len_reg[p] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (cmd.capture)
        begin
            q_rdata_reg <= queue_mem[q_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            status_mem[s_waddr] <= s_wdata;
        end
        if (cmd.capture)
        begin
            s_rdata_reg <= status_mem[IDW'(job_number_in)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode_t'(opcode_in);
            prio_reg <= prio_clamped;
            jnum_reg <= job_number_in;
            ok_reg   <= success_in;
        end
        if (cmd.commit)
        begin
            res_status_reg  <= res_status_next;
            res_id_reg      <= res_id_next;
            res_queued_reg  <= queued_next;
            res_running_reg <= running_next;
            res_done_reg    <= done_next;
            res_bad_reg     <= bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PRIORITY_LEVELS; p++)
            begin
                head_reg[p] <= '0;
                tail_reg[p] <= '0;
                len_reg[p]  <= '0;
            end
            slots_reg   <= '0;
            queued_reg  <= '0;
            running_reg <= '0;
            done_reg    <= '0;
            bad_reg     <= '0;
            limit_reg   <= LIMIT_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                for (int p = 0; p < PRIORITY_LEVELS; p++)
                begin
                    head_reg[p] <= head_next[p];
                    tail_reg[p] <= tail_next[p];
                    len_reg[p]  <= len_next[p];
                end
                slots_reg   <= slots_next;
                queued_reg  <= queued_next;
                running_reg <= running_next;
                done_reg    <= done_next;
                bad_reg     <= bad_next;
            end
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    assign result_data = {
        {PAD_W{1'b0}},
        COUNT_W'(res_bad_reg),
        COUNT_W'(res_done_reg),
        res_running_reg,
        COUNT_W'(res_queued_reg),
        JOB_ID_W'(res_id_reg),
        res_status_reg
    };

endmodule

/* sim/priority_job_dispatcher_tb.sv */
// Self-checking testbench for the strict-priority job dispatcher.
`timescale 1ns / 1ps

module priority_job_dispatcher_tb;

    import pjd_pkg::*;

    localparam int MAX_JOBS    = MAX_JOBS_DEF;
    localparam int PRIO_LEVELS = PRIORITY_LEVELS_DEF;
    localparam int STUCK_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;

    typedef struct packed {
        opcode_t               op;
        logic [PRIO_REQ_W-1:0] prio;
        logic [JOB_NUM_W-1:0]  jnum;
        logic                  ok;
    } job_cmd_t;

    typedef struct packed {
        result_t              status;
        logic [JOB_ID_W-1:0]  job_id;
        logic [COUNT_W-1:0]   queued;
        logic [RUNNING_W-1:0] running;
        logic [COUNT_W-1:0]   done;
        logic [COUNT_W-1:0]   failed;
    } job_outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wen = 1'b0;
    logic [LIMIT_W-1:0]    cfg_wdata = '0;

    priority_job_dispatcher uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Shadow state of the dispatcher.
    job_state_t         job_phase [0:MAX_JOBS-1];
    logic [JOB_ID_W-1:0] fifo_ring [0:PRIO_LEVELS-1][0:MAX_JOBS-1];
    int                 fifo_head [0:PRIO_LEVELS-1];
    int                 fifo_len [0:PRIO_LEVELS-1];
    int                 slots_taken = 0;
    int                 jobs_running = 0;
    int                 jobs_done = 0;
    int                 jobs_failed = 0;
    logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
    int                 running_ids [$];

    job_cmd_t     cmd_backlog [$];
    job_outcome_t due_outcomes [$];
    job_cmd_t     bus_cmd;
    job_outcome_t wanted;

    int  err_count = 0;
    int  cmds_sent = 0;
    int  rx_beats = 0;
    int  adds_issued = 0;
    int  cfg_writes = 0;
    int  tx_gap = 0;
    int  stall_left = 0;
    int  stuck_cycles = 0;
    int  status_seen [0:4] = '{0, 0, 0, 0, 0};
    bit  long_hold_done = 1'b0;
    bit  quiet = 1'b0;

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 50)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic run_command_model(input job_cmd_t c);
        job_outcome_t o;
        int lvl;
        int tail;
        int eff_limit;
        int p;
        int idx;
        int total;
        bit found;
        o = '0;
        o.status = RES_OK;
        case (c.op)
            OP_ADD:
            begin
                if (slots_taken >= MAX_JOBS)
                    o.status = RES_TABLE_FULL;
                else
                begin
                    lvl = (c.prio >= PRIO_LEVELS) ? PRIO_LEVELS - 1 : int'(c.prio);
                    job_phase[slots_taken] = JS_QUEUED;
                    tail = (fifo_head[lvl] + fifo_len[lvl]) % MAX_JOBS;
                    fifo_ring[lvl][tail] = JOB_ID_W'(slots_taken);
                    fifo_len[lvl]++;
                    o.job_id = JOB_ID_W'(slots_taken);
                    slots_taken++;
                end
            end
            OP_DISPATCH:
            begin
                eff_limit = (limit_reg == 0) ? 1 : int'(limit_reg);
                if (jobs_running >= eff_limit)
                    o.status = RES_LIMIT;
                else
                begin
                    o.status = RES_EMPTY;
                    found = 1'b0;
                    for (p = 0; p < PRIO_LEVELS; p++)
                    begin
                        if (!found && fifo_len[p] > 0)
                        begin
                            found = 1'b1;
                            o.job_id = fifo_ring[p][fifo_head[p]];
                            fifo_head[p] = (fifo_head[p] + 1) % MAX_JOBS;
                            fifo_len[p]--;
                            job_phase[o.job_id] = JS_RUNNING;
                            jobs_running++;
                            running_ids.push_back(int'(o.job_id));
                            o.status = RES_OK;
                        end
                    end
                end
            end
            OP_COMPLETE:
            begin
                if (int'(c.jnum) >= slots_taken || job_phase[c.jnum] != JS_RUNNING)
                    o.status = RES_NOT_RUNNING;
                else
                begin
                    job_phase[c.jnum] = c.ok ? JS_DONE : JS_FAILED;
                    jobs_running--;
                    if (c.ok)
                        jobs_done++;
                    else
                        jobs_failed++;
                    o.job_id = c.jnum;
                    found = 1'b0;
                    for (idx = 0; idx < running_ids.size(); idx++)
                    begin
                        if (!found && running_ids[idx] == int'(c.jnum))
                        begin
                            found = 1'b1;
                            running_ids.delete(idx);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        total = 0;
        for (p = 0; p < PRIO_LEVELS; p++)
            total += fifo_len[p];
        o.queued  = COUNT_W'(total);
        o.running = RUNNING_W'(jobs_running);
        o.done    = COUNT_W'(jobs_done);
        o.failed  = COUNT_W'(jobs_failed);
        due_outcomes.push_back(o);
    endtask

    // Command driver: a beat is followed now and then by a burst of idle cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                run_command_model(bus_cmd);
                cmds_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    bus_cmd = cmd_backlog.pop_front();
                    s_tuser <= bus_cmd.op;
                    s_tdata <= {3'b000, bus_cmd.ok, bus_cmd.jnum, bus_cmd.prio};
                    s_tvalid <= 1'b1;
                    if (!quiet && ((cmds_sent / 80) % 4) != 3 && $urandom_range(0, 5) == 0)
                        tx_gap = $urandom_range(1, 12);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off to back the block up.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                rx_beats++;
            if (rx_beats >= 60 && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !quiet && ((rx_beats / 64) % 4) != 3 &&
                     $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_outcomes.size() == 0)
                report_mismatch($sformatf("result beat %h with nothing expected", m_tdata));
            else
            begin
                wanted = due_outcomes.pop_front();
                status_seen[wanted.status]++;
                check_field("status", m_tdata[2:0], wanted.status);
                check_field("job_id", m_tdata[11:3], wanted.job_id);
                check_field("queued_total", m_tdata[21:12], wanted.queued);
                check_field("running_count", m_tdata[28:22], wanted.running);
                check_field("completed_count", m_tdata[38:29], wanted.done);
                check_field("failed_count", m_tdata[48:39], wanted.failed);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cmd_backlog.size() == 0 && !s_tvalid && due_outcomes.size() == 0))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Timeout after %0d cycles without a beat", STUCK_LIMIT);
            $display("priority_job_dispatcher_tb: errors");
            $finish;
        end
    end

    task automatic queue_cmd(input opcode_t op, input int prio, input int jnum, input int ok);
        job_cmd_t c;
        while (cmd_backlog.size() >= 4)
            @(negedge clk);
        c.op   = op;
        c.prio = PRIO_REQ_W'(prio);
        c.jnum = JOB_NUM_W'(jnum);
        c.ok   = 1'(ok);
        if (op == OP_ADD)
            adds_issued++;
        cmd_backlog.push_back(c);
    endtask

    task automatic random_cmd(input int add_pct);
        int r;
        int rest;
        int prio;
        r = $urandom_range(0, 99);
        rest = 100 - add_pct;
        prio = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
        if (r < add_pct)
            queue_cmd(OP_ADD, prio, $urandom_range(0, 511), $urandom_range(0, 1));
        else if (r < add_pct + rest * 55 / 100)
            queue_cmd(OP_DISPATCH, prio, $urandom_range(0, 511), $urandom_range(0, 1));
        else if (r < add_pct + rest * 95 / 100)
        begin
            if (running_ids.size() != 0 && $urandom_range(0, 4) != 0)
                queue_cmd(OP_COMPLETE, prio,
                          running_ids[$urandom_range(0, running_ids.size() - 1)],
                          $urandom_range(0, 1));
            else
                queue_cmd(OP_COMPLETE, prio, $urandom_range(0, 511), $urandom_range(0, 1));
        end
        else
            queue_cmd(OP_NONE, $urandom_range(0, 7), $urandom_range(0, 511),
                      $urandom_range(0, 1));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || s_tvalid || due_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_wdata <= value;
        cfg_wen <= 1'b1;
        @(posedge clk);
        cfg_wen <= 1'b0;
        limit_reg = value;
        cfg_writes++;
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] phase_limits [0:4];
        int ph;
        for (ph = 0; ph < PRIO_LEVELS; ph++)
        begin
            fifo_head[ph] = 0;
            fifo_len[ph] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty block, unknown job, the no-op, then adds at priorities 7, 5, 1 and 0.
        queue_cmd(OP_DISPATCH, 0, 0, 0);
        queue_cmd(OP_COMPLETE, 0, 511, 1);
        queue_cmd(OP_NONE, 7, 511, 1);
        queue_cmd(OP_ADD, 7, 0, 0);
        queue_cmd(OP_ADD, 5, 0, 0);
        queue_cmd(OP_ADD, 1, 0, 0);
        queue_cmd(OP_ADD, 0, 0, 0);
        queue_cmd(OP_DISPATCH, 0, 0, 0);
        queue_cmd(OP_DISPATCH, 0, 0, 0);
        queue_cmd(OP_DISPATCH, 0, 0, 0);
        queue_cmd(OP_COMPLETE, 0, 3, 1);
        queue_cmd(OP_COMPLETE, 0, 2, 0);
        queue_cmd(OP_COMPLETE, 0, 2, 1);
        queue_cmd(OP_COMPLETE, 0, 0, 1);

        // A zero limit acts as one; the limit is checked before the queues.
        wait_idle();
        write_limit('0);
        queue_cmd(OP_DISPATCH, 0, 0, 0);
        queue_cmd(OP_DISPATCH, 0, 0, 0);
        queue_cmd(OP_COMPLETE, 0, 0, 1);
        queue_cmd(OP_DISPATCH, 0, 0, 0);
        queue_cmd(OP_DISPATCH, 0, 0, 0);
        queue_cmd(OP_COMPLETE, 0, 1, 0);
        queue_cmd(OP_DISPATCH, 0, 0, 0);

        phase_limits[0] = 7'd127;
        phase_limits[1] = 7'd1;
        phase_limits[2] = 7'd64;
        phase_limits[3] = LIMIT_W'($urandom_range(1, 64));
        phase_limits[4] = 7'd3;
        for (ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            write_limit(phase_limits[ph]);
            repeat (20) random_cmd(50);
        end

        // Fill the table to the end, then try to add past it.
        wait_idle();
        write_limit(7'd96);
        quiet = 1'b1;
        while (adds_issued < MAX_JOBS + 4)
            random_cmd(97);
        repeat (8) random_cmd(0);

        wait_idle();
        repeat (20) @(negedge clk);
        if (due_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_outcomes.size()));
        $display("Covered %0d commands under %0d limit settings; %0d of %0d slots taken.",
                 cmds_sent, cfg_writes, slots_taken, MAX_JOBS);
        $display("Outcomes: ok %0d, table full %0d, limit %0d, nothing queued %0d, not running %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
        if (err_count == 0)
            $display("priority_job_dispatcher_tb: clean");
        else
            $display("priority_job_dispatcher_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
src/pjd_pkg.sv
src/pjd_ctrl.sv
src/pjd_datapath.sv
src/priority_job_dispatcher.sv
sim/priority_job_dispatcher_tb.sv
